### src/wlan_ie_security_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// WLAN IE security classifier assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WLAN_IE_SECURITY_CLASSIFIER_UNIT_ASSERT_SVH
`define WLAN_IE_SECURITY_CLASSIFIER_UNIT_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define WICS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define WICS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/wics_pkg.sv
// ----------------------------------------------------------------------------
// WLAN IE security classifier package
// Field widths, element codes, result codes and shared types.
// ----------------------------------------------------------------------------
package wics_pkg;

  localparam int unsigned SsidMaxLenDef = 32;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned CAP_W  = 16;

  // Element ids
  localparam logic [BYTE_W-1:0] ELEM_SSID   = 8'd0;
  localparam logic [BYTE_W-1:0] ELEM_RSN    = 8'd48;
  localparam logic [BYTE_W-1:0] ELEM_VENDOR = 8'd221;

  // Minimum vendor body length to hold the WPA OUI and type
  localparam logic [BYTE_W-1:0] WPA_HDR_LEN = 8'd4;

  // Privacy bit in the capability word
  localparam int unsigned PRIV_BIT = 4;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_HIDDEN = 2'd1,
    KIND_NAMED  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    SEC_OPEN     = 3'd0,
    SEC_WEP      = 3'd1,
    SEC_WPA      = 3'd2,
    SEC_WPA2     = 3'd3,
    SEC_WPA_WPA2 = 3'd4
  } sec_e;

  // Frame summary handed from the parser to the result sequencer
  typedef struct packed {
    kind_e            kind;
    logic [LEN_W-1:0] len;
    sec_e             sec;
    logic             keep;
    logic             bank;
  } run_t;

  // WPA vendor prefix 00 50 F2 01
  function automatic logic [BYTE_W-1:0] wpa_oui_byte(input logic [1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'hF2;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

### src/wics_ssid_ram.sv
// ----------------------------------------------------------------------------
// WICS SSID store
// Two banks of SSID bytes, one write port and one registered read port.
// ----------------------------------------------------------------------------
module wics_ssid_ram #(
  parameter int unsigned Depth = 2 * wics_pkg::SsidMaxLenDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [wics_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [wics_pkg::BYTE_W-1:0] rdata_o
);

  logic [wics_pkg::BYTE_W-1:0] mem [Depth];
  logic [wics_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/wics_parser.sv
// ----------------------------------------------------------------------------
// WICS element parser
// Walks id/length/body triples one byte per transfer, stores SSID bodies,
// tracks RSN/WPA flags and forms the frame summary on the last byte.
// ----------------------------------------------------------------------------
`include "wlan_ie_security_classifier_unit_assert.svh"

module wics_parser #(
  parameter int unsigned SsidMaxLen = wics_pkg::SsidMaxLenDef,
  parameter int unsigned AddrW      = $clog2(2 * SsidMaxLen)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [wics_pkg::BYTE_W-1:0] ie_byte_i,
  input  logic                        last_byte_i,
  input  logic [wics_pkg::CAP_W-1:0]  capability_i,
  input  logic                        capability_present_i,
  output logic                        wr_en_o,
  output logic [AddrW-1:0]            wr_addr_o,
  output logic [wics_pkg::BYTE_W-1:0] wr_data_o,
  output logic                        frame_done_o,
  output wics_pkg::run_t              run_o
);

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_BODY
  } phase_e;

  localparam logic [wics_pkg::BYTE_W-1:0] MaxLen = wics_pkg::BYTE_W'(SsidMaxLen);

  phase_e                      phase_q, phase_d;
  logic [wics_pkg::BYTE_W-1:0] elem_id_q, elem_id_d;
  logic [wics_pkg::BYTE_W-1:0] elem_len_q, elem_len_d;
  logic [wics_pkg::BYTE_W-1:0] body_cnt_q, body_cnt_d;
  logic                        oui_q, oui_d;
  logic                        rsn_q, rsn_d;
  logic                        wpa_q, wpa_d;
  logic                        bank_q, bank_d;
  wics_pkg::kind_e             kind_q, kind_d;
  logic [wics_pkg::LEN_W-1:0]  clen_q, clen_d;
  logic                        fin;

  always_comb begin
    phase_d    = phase_q;
    elem_id_d  = elem_id_q;
    elem_len_d = elem_len_q;
    body_cnt_d = body_cnt_q;
    oui_d      = oui_q;
    rsn_d      = rsn_q;
    wpa_d      = wpa_q;
    bank_d     = bank_q;
    kind_d     = kind_q;
    clen_d     = clen_q;
    fin        = 1'b0;
    wr_en_o    = 1'b0;
    wr_data_o  = ie_byte_i;
    wr_addr_o  = bank_q ? AddrW'(SsidMaxLen) + AddrW'(body_cnt_q) : AddrW'(body_cnt_q);

    if (accept_i) begin
      unique case (phase_q)
        PH_ID: begin
          elem_id_d = ie_byte_i;
          phase_d   = PH_LEN;
        end
        PH_LEN: begin
          elem_len_d = ie_byte_i;
          body_cnt_d = '0;
          oui_d      = 1'b1;
          if (ie_byte_i == '0) begin
            fin = 1'b1;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (elem_id_q == wics_pkg::ELEM_SSID && body_cnt_q < MaxLen) begin
            wr_en_o = 1'b1;
          end
          if (body_cnt_q < wics_pkg::WPA_HDR_LEN &&
              ie_byte_i != wics_pkg::wpa_oui_byte(body_cnt_q[1:0])) begin
            oui_d = 1'b0;
          end
          body_cnt_d = body_cnt_q + 1'b1;
          if (body_cnt_d == elem_len_q) begin
            fin = 1'b1;
          end
        end
        default: phase_d = PH_ID;
      endcase
    end

    // Element takes effect on its final byte
    if (fin) begin
      phase_d = PH_ID;
      if (elem_id_d == wics_pkg::ELEM_SSID) begin
        if (elem_len_d != '0 && elem_len_d <= MaxLen) begin
          kind_d = wics_pkg::KIND_NAMED;
          clen_d = elem_len_d[wics_pkg::LEN_W-1:0];
          bank_d = ~bank_q;
        end else begin
          kind_d = wics_pkg::KIND_HIDDEN;
          clen_d = '0;
        end
      end else if (elem_id_d == wics_pkg::ELEM_RSN) begin
        rsn_d = 1'b1;
      end else if (elem_id_d == wics_pkg::ELEM_VENDOR) begin
        if (elem_len_d >= wics_pkg::WPA_HDR_LEN && oui_d) begin
          wpa_d = 1'b1;
        end
      end
    end

    run_o.kind = kind_d;
    run_o.len  = clen_d;
    run_o.keep = (kind_d != wics_pkg::KIND_NONE);
    run_o.bank = ~bank_d;
    if (rsn_d && wpa_d) begin
      run_o.sec = wics_pkg::SEC_WPA_WPA2;
    end else if (rsn_d) begin
      run_o.sec = wics_pkg::SEC_WPA2;
    end else if (wpa_d) begin
      run_o.sec = wics_pkg::SEC_WPA;
    end else if (capability_present_i && capability_i[wics_pkg::PRIV_BIT]) begin
      run_o.sec = wics_pkg::SEC_WEP;
    end else begin
      run_o.sec = wics_pkg::SEC_OPEN;
    end

    frame_done_o = accept_i && last_byte_i;

    // Per-frame state restarts after the frame end; bank and store persist
    if (frame_done_o) begin
      phase_d    = PH_ID;
      elem_id_d  = '0;
      elem_len_d = '0;
      body_cnt_d = '0;
      oui_d      = 1'b1;
      rsn_d      = 1'b0;
      wpa_d      = 1'b0;
      kind_d     = wics_pkg::KIND_NONE;
      clen_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ID;
      elem_id_q  <= '0;
      elem_len_q <= '0;
      body_cnt_q <= '0;
      oui_q      <= 1'b1;
      rsn_q      <= 1'b0;
      wpa_q      <= 1'b0;
      bank_q     <= 1'b0;
      kind_q     <= wics_pkg::KIND_NONE;
      clen_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      elem_id_q  <= elem_id_d;
      elem_len_q <= elem_len_d;
      body_cnt_q <= body_cnt_d;
      oui_q      <= oui_d;
      rsn_q      <= rsn_d;
      wpa_q      <= wpa_d;
      bank_q     <= bank_d;
      kind_q     <= kind_d;
      clen_q     <= clen_d;
    end
  end

  `WICS_ASSERT(a_body_nonzero_len, phase_q == PH_BODY |-> elem_len_q != '0, "body phase with zero length")
  `WICS_ASSERT(a_frame_restart, frame_done_o |=> phase_q == PH_ID && !rsn_q && !wpa_q && kind_q == wics_pkg::KIND_NONE, "frame state not cleared")
  `WICS_ASSERT_NEVER(a_wr_outside_body, wr_en_o && phase_q != PH_BODY, "store write outside body")

endmodule

### src/wics_emitter.sv
// ----------------------------------------------------------------------------
// WICS result sequencer
// Steps through the committed SSID one byte per cycle unless output stalls,
// reading the store into a stage register, then into the output register.
// ----------------------------------------------------------------------------
`include "wlan_ie_security_classifier_unit_assert.svh"

module wics_emitter #(
  parameter int unsigned SsidMaxLen = wics_pkg::SsidMaxLenDef,
  parameter int unsigned AddrW      = $clog2(2 * SsidMaxLen)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  wics_pkg::run_t              run_i,
  output logic                        busy_o,
  output logic                        rd_en_o,
  output logic [AddrW-1:0]            rd_addr_o,
  input  logic [wics_pkg::BYTE_W-1:0] rd_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [wics_pkg::BYTE_W-1:0] ssid_byte_o,
  output logic [wics_pkg::IDX_W-1:0]  ssid_index_o,
  output logic [1:0]                  ssid_kind_o,
  output logic [wics_pkg::LEN_W-1:0]  ssid_length_o,
  output logic [2:0]                  security_o,
  output logic                        keep_o,
  output logic                        last_result_o
);

  // run bookkeeping
  wics_pkg::run_t             run_q;
  logic [wics_pkg::LEN_W-1:0] cnt_q, cnt_d;
  logic [wics_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [wics_pkg::LEN_W-1:0] n;
  logic                       named_run;

  // read stage (data sits in the store's read register)
  logic                       s1_vld_q, s1_vld_d;
  wics_pkg::run_t             s1_run_q;
  logic [wics_pkg::IDX_W-1:0] s1_idx_q;
  logic                       s1_last_q;

  // output register
  logic                        out_vld_q, out_vld_d;
  logic [wics_pkg::BYTE_W-1:0] out_byte_q;
  logic [wics_pkg::IDX_W-1:0]  out_idx_q;
  wics_pkg::kind_e             out_kind_q;
  logic [wics_pkg::LEN_W-1:0]  out_len_q;
  wics_pkg::sec_e              out_sec_q;
  logic                        out_keep_q;
  logic                        out_last_q;

  logic out_load;
  logic issue;

  assign named_run = run_i.kind == wics_pkg::KIND_NAMED && run_i.len != '0 &&
                     int'(run_i.len) <= int'(SsidMaxLen);
  assign n         = named_run ? run_i.len : wics_pkg::LEN_W'(1);

  assign busy_o   = cnt_q != '0;
  assign out_load = s1_vld_q && (!out_vld_q || out_ready_i);
  assign issue    = busy_o && (!s1_vld_q || out_load);

  assign rd_en_o   = issue;
  assign rd_addr_o = run_q.bank ? AddrW'(SsidMaxLen) + AddrW'(idx_q) : AddrW'(idx_q);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (start_i) begin
      cnt_d = n;
      idx_d = '0;
    end else if (issue) begin
      cnt_d = cnt_q - 1'b1;
      idx_d = idx_q + 1'b1;
    end

    if (issue) begin
      s1_vld_d = 1'b1;
    end else if (out_load) begin
      s1_vld_d = 1'b0;
    end else begin
      s1_vld_d = s1_vld_q;
    end

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      idx_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      run_q <= run_i;
    end
    if (issue) begin
      s1_run_q  <= run_q;
      s1_idx_q  <= idx_q;
      s1_last_q <= cnt_q == wics_pkg::LEN_W'(1);
    end
    if (out_load) begin
      out_byte_q <= (s1_run_q.kind == wics_pkg::KIND_NAMED) ? rd_data_i : '0;
      out_idx_q  <= s1_idx_q;
      out_kind_q <= s1_run_q.kind;
      out_len_q  <= s1_run_q.len;
      out_sec_q  <= s1_run_q.sec;
      out_keep_q <= s1_run_q.keep;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign ssid_byte_o   = out_byte_q;
  assign ssid_index_o  = out_idx_q;
  assign ssid_kind_o   = out_kind_q;
  assign ssid_length_o = out_len_q;
  assign security_o    = out_sec_q;
  assign keep_o        = out_keep_q;
  assign last_result_o = out_last_q;

  `WICS_ASSERT_NEVER(a_start_while_busy, start_i && busy_o, "frame end taken during a run")
  `WICS_ASSERT(a_last_tagged, issue && cnt_q == wics_pkg::LEN_W'(1) |=> s1_vld_q && s1_last_q, "final read not tagged last")
  `WICS_ASSERT(a_unnamed_single, out_vld_q && out_kind_q != wics_pkg::KIND_NAMED |-> out_last_q && out_idx_q == '0 && out_len_q == '0, "unnamed run not a single zero result")

endmodule

### src/wlan_ie_security_classifier_unit.sv
// ----------------------------------------------------------------------------
// WLAN IE security classifier
// Parses an information-element byte stream, classifies security and
// emits the SSID of each frame as a run of results.
// ----------------------------------------------------------------------------
//  channel  | signals                             | moves
//  ---------+-------------------------------------+-----------------------
//  in       | in_valid_i / in_ready_o             | one IE byte per transfer
//  out      | out_valid_o / out_ready_i           | one SSID byte per transfer
//
// Bytes are taken one per cycle while no run is reading; the parser state updates
// in the accepting cycle. On a last byte the run of n results (SSID length, or 1)
// reads the store one byte per cycle unless output stalls; intake pauses until
// its last read issues. Results pass through a read stage and an output register,
// so output stalls back up into the run but not into bytes already accepted.
// Reset clears all control state; the SSID store is not cleared.
// ----------------------------------------------------------------------------
module wlan_ie_security_classifier_unit #(
  parameter int unsigned SsidMaxLen = wics_pkg::SsidMaxLenDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [wics_pkg::BYTE_W-1:0] ie_byte_i,
  input  logic                        last_byte_i,
  input  logic [wics_pkg::CAP_W-1:0]  capability_i,
  input  logic                        capability_present_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [wics_pkg::BYTE_W-1:0] ssid_byte_o,
  output logic [wics_pkg::IDX_W-1:0]  ssid_index_o,
  output logic [1:0]                  ssid_kind_o,
  output logic [wics_pkg::LEN_W-1:0]  ssid_length_o,
  output logic [2:0]                  security_o,
  output logic                        keep_o,
  output logic                        last_result_o
);

  localparam int unsigned Depth = 2 * SsidMaxLen;
  localparam int unsigned AddrW = $clog2(Depth);

  logic                        accept;
  logic                        busy;
  logic                        wr_en;
  logic [AddrW-1:0]            wr_addr;
  logic [wics_pkg::BYTE_W-1:0] wr_data;
  logic                        frame_done;
  wics_pkg::run_t              run;
  logic                        rd_en;
  logic [AddrW-1:0]            rd_addr;
  logic [wics_pkg::BYTE_W-1:0] rd_data;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  wics_parser #(
    .SsidMaxLen(SsidMaxLen),
    .AddrW     (AddrW)
  ) u_parser (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .ie_byte_i           (ie_byte_i),
    .last_byte_i         (last_byte_i),
    .capability_i        (capability_i),
    .capability_present_i(capability_present_i),
    .wr_en_o             (wr_en),
    .wr_addr_o           (wr_addr),
    .wr_data_o           (wr_data),
    .frame_done_o        (frame_done),
    .run_o               (run)
  );

  wics_ssid_ram #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_ssid_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  wics_emitter #(
    .SsidMaxLen(SsidMaxLen),
    .AddrW     (AddrW)
  ) u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (frame_done),
    .run_i        (run),
    .busy_o       (busy),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ssid_byte_o  (ssid_byte_o),
    .ssid_index_o (ssid_index_o),
    .ssid_kind_o  (ssid_kind_o),
    .ssid_length_o(ssid_length_o),
    .security_o   (security_o),
    .keep_o       (keep_o),
    .last_result_o(last_result_o)
  );

endmodule
